[design/sensor_ascii_frame_formatter_assert.svh]
// Assertion macros used by the frame formatter checker.
`ifndef SENSOR_ASCII_FRAME_FORMATTER_ASSERT_SVH
`define SENSOR_ASCII_FRAME_FORMATTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, muted while rst is high
`define SAFF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame formatter check failed");

// Next-cycle implication, sampled on clk, muted while rst is high
`define SAFF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame formatter check failed");

`endif

[design/saff_pkg.sv]
// Shared types, constants and the frame layout table of the frame formatter.
package saff_pkg;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_NODE_ADDRESS = 1'b0;
  localparam logic [7:0] NODE_ADDR_RESET = 8'd49;

  // Frame bytes
  localparam logic [7:0] BYTE_STX   = 8'h02;
  localparam logic [7:0] BYTE_DC4   = 8'h14;
  localparam logic [7:0] BYTE_COMMA = 8'h2c;
  localparam logic [7:0] BYTE_DOT   = 8'h2e;
  localparam logic [7:0] BYTE_STAR  = 8'h2a;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;

  localparam int FRAME_LEN = 50;
  localparam int POS_W     = 6;

  // Fixed-point digit extraction: the reading times the constant, low FRAC_W
  // bits, is a binary fraction whose decimal digits are the wanted digits.
  localparam int FRAC_W = 40;
  localparam int MUL_W  = 27;
  // ceil(2^40 / 10^4): fraction of v / 10^4, ten-thousands digit wraps away
  localparam logic [MUL_W-1:0] MUL_TENTHS = 27'd109951163;
  // ceil(2^40 / 10^5): fraction of v / 10^5, all five digits
  localparam logic [MUL_W-1:0] MUL_FIVE   = 27'd10995117;

  // One input item, first field in the highest bits
  typedef struct packed {
    logic [15:0] tank_temp;
    logic [15:0] acidity;
    logic [15:0] conductivity;
    logic [15:0] dissolved_oxygen;
    logic [15:0] light_level;
    logic [15:0] air_humidity;
    logic [15:0] ambient_temp;
  } item_t;

  typedef enum logic [2:0] {
    FLD_AMBIENT_TEMP,
    FLD_AIR_HUMIDITY,
    FLD_LIGHT_LEVEL,
    FLD_DISSOLVED_OXYGEN,
    FLD_CONDUCTIVITY,
    FLD_ACIDITY,
    FLD_TANK_TEMP
  } field_t;

  typedef enum logic [1:0] {
    SLOT_LIT,
    SLOT_ADDR,
    SLOT_DIGIT,
    SLOT_SEP
  } slot_kind_t;

  // What one frame position emits
  typedef struct packed {
    slot_kind_t  kind;
    logic [7:0]  lit;
    field_t      field;
    logic        tenths;
    logic        last;
  } slot_t;

  // Control from the frame sequencer to the digit unit
  typedef struct packed {
    logic load;
    logic step;
    logic tenths;
  } digit_ctl_t;

  // Frame layout: a separator beat also loads the digit unit with the next field
  function automatic slot_t slot_of(input logic [POS_W-1:0] pos);
    slot_t s;
    s.kind   = SLOT_LIT;
    s.lit    = BYTE_STX;
    s.field  = FLD_AMBIENT_TEMP;
    s.tenths = 1'b0;
    s.last   = 1'b0;
    case (pos)
      6'd0, 6'd1: s.lit = BYTE_STX;
      6'd2:       s.lit = BYTE_DC4;
      6'd3:       s.kind = SLOT_ADDR;
      6'd4: begin
        s.kind = SLOT_SEP; s.field = FLD_AMBIENT_TEMP; s.tenths = 1'b1;
      end
      6'd10: begin
        s.kind = SLOT_SEP; s.field = FLD_AIR_HUMIDITY; s.tenths = 1'b1;
      end
      6'd16: begin
        s.kind = SLOT_SEP; s.field = FLD_LIGHT_LEVEL;
      end
      6'd22: begin
        s.kind = SLOT_SEP; s.field = FLD_DISSOLVED_OXYGEN;
      end
      6'd29: begin
        s.kind = SLOT_SEP; s.field = FLD_CONDUCTIVITY;
      end
      6'd36: begin
        s.kind = SLOT_SEP; s.field = FLD_ACIDITY;
      end
      6'd43: begin
        s.kind = SLOT_SEP; s.field = FLD_TANK_TEMP; s.tenths = 1'b1;
      end
      6'd8, 6'd14, 6'd25, 6'd32, 6'd39, 6'd47: s.lit = BYTE_DOT;
      6'd5, 6'd6, 6'd7, 6'd9,
      6'd11, 6'd12, 6'd13, 6'd15,
      6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
      6'd23, 6'd24, 6'd26, 6'd27, 6'd28,
      6'd30, 6'd31, 6'd33, 6'd34, 6'd35,
      6'd37, 6'd38, 6'd40, 6'd41, 6'd42,
      6'd44, 6'd45, 6'd46, 6'd48: s.kind = SLOT_DIGIT;
      6'd49: begin
        s.lit  = BYTE_STAR;
        s.last = 1'b1;
      end
      default: begin
        s.lit  = BYTE_STAR;
        s.last = 1'b1;
      end
    endcase
    return s;
  endfunction

endpackage

[design/sensor_ascii_frame_formatter.sv]
// Top level of the sensor ASCII telemetry frame formatter.
// Each accepted reading set becomes one 50-byte ASCII frame on the output stream, one byte
// per beat, with tlast on the closing '*'. A reading set passes the input register and the
// sequencer's item register before its first byte leaves the output register. A one-entry
// input register takes the next reading set while the current frame is being sent, so with
// m_tready held high frames follow one another with no gap, paced by the byte-wide output channel.
// The node address register (byte address 0, reset value 0x31) should be written only
// while no frame is pending.
module sensor_ascii_frame_formatter import saff_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // ambient_temp, air_humidity, light_level, dissolved_oxygen, conductivity, acidity,
  // tank_temp: 16 bits each, from bit 0 up
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [111:0]          s_tdata,
  // frame_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,
  output logic                  m_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [7:0] node_address;
  item_t      item;
  logic       item_valid;
  logic       item_take;

  saff_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .node_address (node_address)
  );

  saff_in_buf u_in_buf (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .item       (item),
    .item_valid (item_valid),
    .item_take  (item_take)
  );

  saff_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .node_address (node_address),
    .item         (item),
    .item_valid   (item_valid),
    .item_take    (item_take),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast)
  );

endmodule

[design/saff_cfg.sv]
// Configuration register file: node address behind an APB-style port.
module saff_cfg import saff_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [7:0]            node_address
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Write the node address on the access beat
  always_ff @(posedge clk) begin
    if (rst) begin
      node_address <= NODE_ADDR_RESET;
    end else if (wr_en && paddr[2] == REG_NODE_ADDRESS) begin
      node_address <= pwdata[7:0];
    end
  end

  // Read back
  always_comb begin
    if (paddr[2] == REG_NODE_ADDRESS) begin
      prdata = {24'd0, node_address};
    end else begin
      prdata = '0;
    end
  end

endmodule

[design/saff_in_buf.sv]
// Input register: holds one reading set until the frame sequencer takes it.
module saff_in_buf import saff_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [111:0] s_tdata,
  output item_t        item,
  output logic         item_valid,
  input  logic         item_take
);

  logic pend_valid;

  assign s_tready   = !pend_valid;
  assign item_valid = pend_valid;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      pend_valid <= 1'b1;
    end else if (item_take) begin
      pend_valid <= 1'b0;
    end
  end

  // Capture the beat
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= item_t'(s_tdata);
    end
  end

endmodule

[design/saff_digit.sv]
// Digit unit: scales a reading to a binary fraction, then yields one decimal digit per step.
module saff_digit import saff_pkg::*; (
  input  logic        clk,
  input  digit_ctl_t  ctl,
  input  logic [15:0] value,
  output logic [3:0]  digit
);

  localparam int PROD_W = 16 + MUL_W;

  logic [MUL_W-1:0]  mult;
  logic [PROD_W-1:0] prod;
  logic [FRAC_W-1:0] frac;
  logic [FRAC_W+3:0] times10;

  // Scale the reading: tenths fields keep only the low four digits
  assign mult = ctl.tenths ? MUL_TENTHS : MUL_FIVE;
  assign prod = {{MUL_W{1'b0}}, value} * {16'd0, mult};

  // Multiply by ten with shift and add; the integer part is the next digit
  assign times10 = ({4'd0, frac} << 3) + ({4'd0, frac} << 1);
  assign digit   = times10[FRAC_W+3:FRAC_W];

  // Load a new field or drop the digit just emitted
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      frac <= prod[FRAC_W-1:0];
    end else if (ctl.step) begin
      frac <= times10[FRAC_W-1:0];
    end
  end

endmodule

[design/saff_emit.sv]
// Frame sequencer: walks the 50 frame positions and drives the output register.
module saff_emit import saff_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] node_address,
  input  item_t      item,
  input  logic       item_valid,
  output logic       item_take,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast
);

  logic [POS_W-1:0] cnt;
  logic             busy;
  item_t            cur;
  slot_t            slot;
  logic             adv;
  logic             last_adv;
  logic [7:0]       byte_next;
  logic [15:0]      value;
  logic [3:0]       digit;
  digit_ctl_t       dctl;

  saff_digit u_digit (
    .clk   (clk),
    .ctl   (dctl),
    .value (value),
    .digit (digit)
  );

  // Decode the current position and pick its byte
  always_comb begin
    slot      = slot_of(cnt);
    adv       = busy && (!m_tvalid || m_tready);
    last_adv  = adv && slot.last;
    item_take = item_valid && (!busy || last_adv);

    case (slot.kind)
      SLOT_LIT:   byte_next = slot.lit;
      SLOT_ADDR:  byte_next = node_address;
      SLOT_DIGIT: byte_next = BYTE_ZERO | {4'd0, digit};
      SLOT_SEP:   byte_next = BYTE_COMMA;
      default:    byte_next = slot.lit;
    endcase

    case (slot.field)
      FLD_AMBIENT_TEMP:     value = cur.ambient_temp;
      FLD_AIR_HUMIDITY:     value = cur.air_humidity;
      FLD_LIGHT_LEVEL:      value = cur.light_level;
      FLD_DISSOLVED_OXYGEN: value = cur.dissolved_oxygen;
      FLD_CONDUCTIVITY:     value = cur.conductivity;
      FLD_ACIDITY:          value = cur.acidity;
      FLD_TANK_TEMP:        value = cur.tank_temp;
      default:              value = cur.ambient_temp;
    endcase

    dctl.load   = adv && slot.kind == SLOT_SEP;
    dctl.step   = adv && slot.kind == SLOT_DIGIT;
    dctl.tenths = slot.tenths;
  end

  // Advance through the frame, restarting at once when another item waits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (item_take) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (last_adv) begin
      busy <= 1'b0;
    end else if (adv) begin
      cnt <= cnt + POS_W'(1);
    end
  end

  // Output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (item_take) begin
      cur <= item;
    end
    if (adv) begin
      m_tdata <= byte_next;
      m_tlast <= slot.last;
    end
  end

endmodule

[design/saff_checker.sv]
// Port-level checks on the frame formatter, bound to its top level.
`include "sensor_ascii_frame_formatter_assert.svh"

module saff_checker import saff_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [7:0]   m_tdata,
  input logic         m_tlast
);

  // A stalled output beat holds
  `SAFF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // Only the closing star carries tlast
  `SAFF_ASSERT_NOW(a_last_is_star, m_tvalid && m_tlast, m_tdata == BYTE_STAR)

  // The beat after a frame end is the start of a new frame, if any
  `SAFF_ASSERT_NEXT(a_frame_start, m_tvalid && m_tready && m_tlast, !m_tvalid || m_tdata == BYTE_STX)

  // The single input register is full right after a beat is taken
  `SAFF_ASSERT_NEXT(a_in_full, s_tvalid && s_tready, !s_tready)

endmodule

bind sensor_ascii_frame_formatter saff_checker u_saff_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
